@@ rtl/core/ats_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helpers for the adaptive trend smoother.
package ats_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int GAP_W     = 16;
  localparam int TC_W      = 13;
  localparam int OG_W      = 17;
  localparam int TREND_W   = 32;
  localparam int Q30_W     = 31;
  localparam int EXP_ARG_W = 20;
  localparam int CFG_W     = 17;
  localparam int IDX_W     = 4;

  localparam logic [Q30_W-1:0] ONE_Q30  = 31'h4000_0000;
  localparam logic [Q30_W-1:0] EXP_SEED = 31'd1073725440;
  localparam logic [TC_W-1:0]  TC_RESET = 13'd2432;

  typedef enum logic {
    REG_TIME_CONSTANT = 1'b0,
    REG_OUTLIER_GAIN  = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_value;
    logic [GAP_W-1:0]    day_gap;
    logic                new_series;
    logic                series_end;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] trend_value;
    logic                run_last;
  } out_item_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_CAPTURE,
    DP_ACC,
    DP_SEED,
    DP_EMIT,
    DP_LOAD,
    DP_PREP,
    DP_ALPHA,
    DP_ZSQ,
    DP_ZG,
    DP_QEXP,
    DP_DEN,
    DP_GAIN,
    DP_STEP
  } dp_op_t;

  typedef enum logic [3:0] {
    CS_IDLE,
    CS_SUM,
    CS_SEED,
    CS_EMIT,
    CS_LOAD,
    CS_PREP,
    CS_ALPHA,
    CS_ZSQ,
    CS_ZG,
    CS_QEXP,
    CS_DEN,
    CS_GAIN,
    CS_STEP
  } ctl_state_t;

  typedef struct packed {
    dp_op_t           op;
    logic             start;
    logic [IDX_W-1:0] idx;
    logic             last;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic div_busy;
    logic exp_busy;
  } dp_stat_t;

  function automatic logic is_multi(input dp_op_t op);
    return (op == DP_SEED) || (op == DP_ALPHA) || (op == DP_QEXP) || (op == DP_GAIN);
  endfunction

  // Round half up from a Q60 product to Q30.
  function automatic logic [33:0] rnd_q30(input logic [63:0] p);
    logic [63:0] s;
    s = p + 64'h2000_0000;
    return s[63:30];
  endfunction

endpackage

@@ rtl/core/ats_datapath.sv @@
`timescale 1ns / 1ps
// Datapath: warm-up buffer, shared multiplier, iterative divider and exponential unit.
module ats_datapath import ats_pkg::*; #(
  parameter int W = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  in_item_t        in_data,
  input  dp_cmd_t         cmd,
  output dp_stat_t        st,
  output out_item_t       out_data
);

  localparam int IW  = (W > 1) ? $clog2(W) : 1;
  localparam int CW  = $clog2(W + 1);
  localparam int SW  = SAMPLE_W + CW;
  localparam int SDW = SW + 8;

  logic [TC_W-1:0]     tc_r;
  logic [OG_W-1:0]     og_r;
  logic [SAMPLE_W-1:0] wv_r [W];
  logic [GAP_W-1:0]    wg_r [W];
  logic [SAMPLE_W-1:0] cur_s_r;
  logic [GAP_W-1:0]    cur_g_r;
  logic [SW-1:0]       sum_r;
  logic [TREND_W-1:0]  trend_r;
  logic [31:0]         m_r;
  logic                neg_r;
  logic [Q30_W-1:0]    a_r;
  logic [Q30_W-1:0]    q_r;
  logic [47:0]         p_r;
  logic [EXP_ARG_W-1:0] z_r;
  logic [Q30_W-1:0]    num_r;
  logic [31:0]         den_r;
  logic [Q30_W-1:0]    gain_r;
  dp_op_t              op_r;
  logic                done_r;
  out_item_t           out_r;

  logic                div_busy_r;
  logic [31:0]         rem_r;
  logic [63:0]         quo_r;
  logic [31:0]         dd_r;
  logic [6:0]          dcnt_r;

  logic                exp_busy_r;
  logic [EXP_ARG_W-1:0] x_r;
  logic [Q30_W-1:0]    r_r;
  logic [Q30_W-1:0]    f_r;
  logic [4:0]          k_r;
  logic                ph_r;

  logic [IW-1:0]       idx;
  logic [31:0]         s_ext;
  logic [32:0]         m8_sum;
  logic [23:0]         m8;
  logic [OG_W-1:0]     g_abs;
  logic [Q30_W-1:0]    n_q30;
  logic [31:0]         mul_a;
  logic [31:0]         mul_b;
  logic [63:0]         prod;
  logic [33:0]         rnd;
  logic [63:0]         zf;
  logic [EXP_ARG_W-1:0] zval;
  logic [32:0]         tsum;
  logic [SAMPLE_W-1:0] tv;
  logic [CW-1:0]       cnt;
  logic [SDW-1:0]      sdiv;
  logic [32:0]         rem_sh;
  logic                ge;
  logic [31:0]         rem_n;
  logic [63:0]         quo_n;
  logic [EXP_ARG_W-1:0] xq;

  assign idx    = cmd.idx[IW-1:0];
  assign s_ext  = {cur_s_r, 8'b0};
  assign m8_sum = {1'b0, m_r} + 33'd128;
  assign m8     = m8_sum[32] ? 24'hFF_FFFF : m8_sum[31:8];
  assign g_abs  = og_r[OG_W-1] ? (~og_r + 17'd1) : og_r;
  assign n_q30  = ONE_Q30 - a_r;

  // One shared multiplier; the exponential unit owns it while it runs.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (exp_busy_r) begin
      mul_a = {1'b0, (ph_r ? f_r : r_r)};
      mul_b = {1'b0, f_r};
    end else begin
      unique case (cmd.op)
        DP_ZSQ: begin
          mul_a = {8'b0, m8};
          mul_b = {8'b0, m8};
        end
        DP_ZG: begin
          mul_a = p_r[31:0];
          mul_b = {15'b0, g_abs};
        end
        DP_DEN: begin
          mul_a = og_r[OG_W-1] ? {1'b0, n_q30} : {1'b0, a_r};
          mul_b = {1'b0, q_r};
        end
        DP_STEP: begin
          mul_a = m_r;
          mul_b = {1'b0, gain_r};
        end
        default: ;
      endcase
    end
  end

  assign prod = mul_a * mul_b;
  assign rnd  = rnd_q30(prod);

  // Outlier exponent argument, saturated at the exponential unit's range.
  assign zf = prod + 64'd2048;
  always_comb begin
    if (g_abs == '0) begin
      zval = '0;
    end else if ((p_r[47:32] != '0) || (zf[63:32] != '0)) begin
      zval = '1;
    end else begin
      zval = zf[31:12];
    end
  end

  assign tsum = {1'b0, trend_r} + 33'd128;
  assign tv   = tsum[32] ? 24'hFF_FFFF : tsum[31:8];

  assign cnt  = CW'(idx) + CW'(1);
  assign sdiv = {sum_r, 8'b0} + SDW'(cnt >> 1);

  assign rem_sh = {rem_r, quo_r[63]};
  assign ge     = rem_sh >= {1'b0, dd_r};
  assign rem_n  = ge ? 32'(rem_sh - {1'b0, dd_r}) : rem_sh[31:0];
  assign quo_n  = {quo_r[62:0], ge};
  assign xq     = (quo_n[63:EXP_ARG_W] != '0) ? '1 : quo_n[EXP_ARG_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tc_r       <= TC_RESET;
      og_r       <= '0;
      div_busy_r <= 1'b0;
      exp_busy_r <= 1'b0;
      done_r     <= 1'b0;
      op_r       <= DP_NOP;
    end else begin
      done_r <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == REG_TIME_CONSTANT) begin
          tc_r <= cfg_wdata[TC_W-1:0];
        end else begin
          og_r <= cfg_wdata[OG_W-1:0];
        end
      end

      if (cmd.start) begin
        unique case (cmd.op)
          DP_CAPTURE: begin
            cur_s_r  <= in_data.sample_value;
            cur_g_r  <= in_data.day_gap;
            wv_r[idx] <= in_data.sample_value;
            wg_r[idx] <= in_data.day_gap;
            sum_r    <= '0;
          end
          DP_ACC: sum_r <= sum_r + SW'(wv_r[idx]);
          DP_SEED: begin
            op_r       <= DP_SEED;
            quo_r      <= {sdiv, (64 - SDW)'(0)};
            rem_r      <= '0;
            dd_r       <= 32'(cnt);
            dcnt_r     <= 7'(SDW);
            div_busy_r <= 1'b1;
          end
          DP_EMIT: begin
            out_r.trend_value <= tv;
            out_r.run_last    <= cmd.last;
          end
          DP_LOAD: begin
            cur_s_r <= wv_r[idx];
            cur_g_r <= wg_r[idx];
          end
          DP_PREP: begin
            neg_r <= s_ext < trend_r;
            m_r   <= (s_ext < trend_r) ? (trend_r - s_ext) : (s_ext - trend_r);
          end
          DP_ALPHA: begin
            op_r <= DP_ALPHA;
            if (tc_r == '0) begin
              a_r    <= '0;
              done_r <= 1'b1;
            end else begin
              quo_r      <= {cur_g_r, 48'b0};
              rem_r      <= '0;
              dd_r       <= {19'b0, tc_r};
              dcnt_r     <= 7'd40;
              div_busy_r <= 1'b1;
            end
          end
          DP_ZSQ: p_r <= prod[47:0];
          DP_ZG:  z_r <= zval;
          DP_QEXP: begin
            op_r       <= DP_QEXP;
            x_r        <= z_r;
            r_r        <= ONE_Q30;
            f_r        <= EXP_SEED;
            k_r        <= '0;
            ph_r       <= 1'b0;
            exp_busy_r <= 1'b1;
          end
          DP_DEN: begin
            if (og_r[OG_W-1]) begin
              num_r <= rnd[Q30_W-1:0];
              den_r <= {1'b0, rnd[Q30_W-1:0]} + {1'b0, a_r};
            end else begin
              num_r <= n_q30;
              den_r <= {1'b0, n_q30} + rnd[31:0];
            end
          end
          DP_GAIN: begin
            op_r <= DP_GAIN;
            if (den_r == '0) begin
              gain_r <= '0;
              done_r <= 1'b1;
            end else begin
              quo_r      <= {num_r, 33'b0};
              rem_r      <= '0;
              dd_r       <= den_r;
              dcnt_r     <= 7'd61;
              div_busy_r <= 1'b1;
            end
          end
          DP_STEP: trend_r <= neg_r ? (trend_r - rnd[31:0]) : (trend_r + rnd[31:0]);
          default: ;
        endcase
      end

      // Restoring divider, one quotient bit per cycle.
      if (div_busy_r) begin
        rem_r  <= rem_n;
        quo_r  <= quo_n;
        dcnt_r <= dcnt_r - 7'd1;
        if (dcnt_r == 7'd1) begin
          div_busy_r <= 1'b0;
          unique case (op_r)
            DP_SEED: begin
              trend_r <= quo_n[31:0];
              done_r  <= 1'b1;
            end
            DP_ALPHA: begin
              x_r        <= xq;
              r_r        <= ONE_Q30;
              f_r        <= EXP_SEED;
              k_r        <= '0;
              ph_r       <= 1'b0;
              exp_busy_r <= 1'b1;
            end
            default: begin
              gain_r <= quo_n[Q30_W-1:0];
              done_r <= 1'b1;
            end
          endcase
        end
      end

      // exp(-x): multiply in exp(-2^(k-16)) for every set bit k, squaring the factor.
      if (exp_busy_r) begin
        if (!ph_r) begin
          if (x_r[k_r]) begin
            r_r <= rnd[Q30_W-1:0];
          end
          ph_r <= 1'b1;
        end else begin
          f_r  <= rnd[Q30_W-1:0];
          ph_r <= 1'b0;
          k_r  <= k_r + 5'd1;
          if (k_r == 5'(EXP_ARG_W - 1)) begin
            exp_busy_r <= 1'b0;
            done_r     <= 1'b1;
            if (op_r == DP_ALPHA) begin
              a_r <= r_r;
            end else begin
              q_r <= r_r;
            end
          end
        end
      end
    end
  end

  assign st.done     = is_multi(cmd.op) ? done_r : cmd.start;
  assign st.div_busy = div_busy_r;
  assign st.exp_busy = exp_busy_r;
  assign out_data    = out_r;

endmodule

@@ rtl/core/ats_controller.sv @@
`timescale 1ns / 1ps
// Controller: sequences warm-up, seeding, trend updates and result beats.
module ats_controller import ats_pkg::*; #(
  parameter int W = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output dp_cmd_t  cmd,
  input  dp_stat_t st
);

  localparam int IW = (W > 1) ? $clog2(W) : 1;
  localparam int CW = $clog2(W + 1);

  ctl_state_t    state_r, state_nxt;
  logic          wait_r, wait_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [IW-1:0] last_r, last_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          seeded_r, seeded_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [CW-1:0] cnt_base;
  logic [CW-1:0] cnt_eff;
  logic [CW-1:0] cnt_plus;
  logic          flush;
  logic          gen;
  dp_op_t        step_op;
  ctl_state_t    step_next;

  assign cnt_base = in_data.new_series ? '0 : cnt_r;
  assign cnt_eff  = (cnt_base >= CW'(W)) ? '0 : cnt_base;
  assign cnt_plus = cnt_eff + CW'(1);
  assign flush    = (cnt_plus == CW'(W)) || in_data.series_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= CS_IDLE;
      wait_r      <= 1'b0;
      idx_r       <= '0;
      last_r      <= '0;
      cnt_r       <= '0;
      seeded_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wait_r      <= wait_nxt;
      idx_r       <= idx_nxt;
      last_r      <= last_nxt;
      cnt_r       <= cnt_nxt;
      seeded_r    <= seeded_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    wait_nxt      = wait_r;
    idx_nxt       = idx_r;
    last_nxt      = last_r;
    cnt_nxt       = cnt_r;
    seeded_nxt    = seeded_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.op        = DP_NOP;
    gen           = 1'b0;
    step_op       = DP_NOP;
    step_next     = CS_IDLE;

    unique case (state_r)
      CS_IDLE: begin
        cmd.op  = DP_CAPTURE;
        cmd.idx = IDX_W'(cnt_eff);
        if (in_valid) begin
          cmd.start = 1'b1;
          if (seeded_r && !in_data.new_series) begin
            idx_nxt   = '0;
            last_nxt  = '0;
            state_nxt = CS_PREP;
          end else begin
            seeded_nxt = 1'b0;
            cnt_nxt    = cnt_plus;
            if (flush) begin
              idx_nxt   = '0;
              last_nxt  = cnt_eff[IW-1:0];
              state_nxt = CS_SUM;
            end
          end
        end
      end
      CS_SUM: begin
        cmd.op    = DP_ACC;
        cmd.idx   = IDX_W'(idx_r);
        cmd.start = 1'b1;
        if (idx_r == last_r) begin
          idx_nxt   = '0;
          state_nxt = CS_SEED;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end
      CS_SEED: begin
        gen       = 1'b1;
        step_op   = DP_SEED;
        step_next = CS_EMIT;
      end
      CS_EMIT: begin
        cmd.op   = DP_EMIT;
        cmd.idx  = IDX_W'(idx_r);
        cmd.last = (idx_r == last_r);
        if (!out_valid_r || !out_stall) begin
          cmd.start     = 1'b1;
          out_valid_nxt = 1'b1;
          if (idx_r == last_r) begin
            seeded_nxt = 1'b1;
            cnt_nxt    = '0;
            state_nxt  = CS_IDLE;
          end else begin
            idx_nxt   = idx_r + IW'(1);
            state_nxt = CS_LOAD;
          end
        end
      end
      CS_LOAD: begin
        cmd.op    = DP_LOAD;
        cmd.idx   = IDX_W'(idx_r);
        cmd.start = 1'b1;
        state_nxt = CS_PREP;
      end
      CS_PREP: begin
        gen = 1'b1; step_op = DP_PREP; step_next = CS_ALPHA;
      end
      CS_ALPHA: begin
        gen = 1'b1; step_op = DP_ALPHA; step_next = CS_ZSQ;
      end
      CS_ZSQ: begin
        gen = 1'b1; step_op = DP_ZSQ; step_next = CS_ZG;
      end
      CS_ZG: begin
        gen = 1'b1; step_op = DP_ZG; step_next = CS_QEXP;
      end
      CS_QEXP: begin
        gen = 1'b1; step_op = DP_QEXP; step_next = CS_DEN;
      end
      CS_DEN: begin
        gen = 1'b1; step_op = DP_DEN; step_next = CS_GAIN;
      end
      CS_GAIN: begin
        gen = 1'b1; step_op = DP_GAIN; step_next = CS_STEP;
      end
      CS_STEP: begin
        gen = 1'b1; step_op = DP_STEP; step_next = CS_EMIT;
      end
      default: state_nxt = CS_IDLE;
    endcase

    // Datapath steps: start once, then hold the command until done comes back.
    if (gen) begin
      cmd.op    = step_op;
      cmd.idx   = IDX_W'(last_r);
      cmd.start = !wait_r;
      if (st.done) begin
        wait_nxt  = 1'b0;
        state_nxt = step_next;
      end else begin
        wait_nxt = 1'b1;
      end
    end
  end

  assign in_stall  = (state_r != CS_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ rtl/core/adaptive_trend_smoother.sv @@
`timescale 1ns / 1ps
// A warm-up-only beat is captured into the buffer. A flush of n samples sums them, seeds the trend
// with a divide and emits the first result beat, then loads, updates and emits each stored sample.
// A seeded sample's update runs two divides and two exponentials (the alpha divide and its
// exponential are skipped with zero tau), all sharing one multiplier. No new sample is taken
// until the last result beat of the current one is emitted, and output stalls hold the flow.
// Reset (synchronous, active low) clears the series state and restores both registers.
module adaptive_trend_smoother import ats_pkg::*; #(
  parameter int WARMUP_SAMPLES = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  dp_cmd_t  cmd;
  dp_stat_t st;

  ats_controller #(.W(WARMUP_SAMPLES)) u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .st        (st)
  );

  ats_datapath #(.W(WARMUP_SAMPLES)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_data  (out_data)
  );

  a_idle_units: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !st.div_busy && !st.exp_busy)
    else $error("arithmetic unit busy while accepting input");

  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
    !(st.div_busy && st.exp_busy))
    else $error("divider and exponential unit active together");

  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.op == DP_EMIT && cmd.start))
    else $error("result beat raised without an emit command");

endmodule
